// ----- rtl/core/cbs_pkg.sv -----
// Shared types and constants for the cube map bilinear sampler.
// No dependencies; used by the top level, cubemap_bilinear_sampler.
package cbs_pkg;

  localparam int MAX_FACE_SIZE = 64;
  localparam int CHANNEL_BITS  = 16;
  localparam int FRAC_BITS     = 8;

  localparam int DIR_W       = 16;
  localparam int CHAN_W      = 16;
  localparam int FACE_SIZE_W = 7;
  localparam logic [FACE_SIZE_W-1:0] FACE_SIZE_RST = 7'd64;

  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  localparam logic [2:0] FACE_PX = 3'd0;
  localparam logic [2:0] FACE_NX = 3'd1;
  localparam logic [2:0] FACE_PY = 3'd2;
  localparam logic [2:0] FACE_NY = 3'd3;
  localparam logic [2:0] FACE_PZ = 3'd4;
  localparam logic [2:0] FACE_NZ = 3'd5;

  typedef struct packed {
    logic                    opcode;
    logic [2:0]              write_face;
    logic [5:0]              texel_col;
    logic [5:0]              texel_row;
    logic [CHAN_W-1:0]       write_red;
    logic [CHAN_W-1:0]       write_green;
    logic [CHAN_W-1:0]       write_blue;
    logic signed [DIR_W-1:0] dir_x;
    logic signed [DIR_W-1:0] dir_y;
    logic signed [DIR_W-1:0] dir_z;
  } in_word_t;

  typedef struct packed {
    logic [2:0]        face_index;
    logic [CHAN_W-1:0] out_red;
    logic [CHAN_W-1:0] out_green;
    logic [CHAN_W-1:0] out_blue;
    logic              zero_dir_error;
  } out_word_t;

endpackage

// ----- rtl/core/cbs_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module cbs_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/core/cbs_div.sv -----
// Pipelined restoring divider, one quotient bit per stage.
// No dependencies; the caller guarantees the quotient fits in QB bits.
module cbs_div #(
  parameter int DSR_W = 16,
  parameter int QB    = 15
) (
  input  logic                  clk,
  input  logic [DSR_W+QB-1:0]   dvd_i,
  input  logic [DSR_W-1:0]      dsr_i,
  output logic [QB-1:0]         quo_o
);

  localparam int W = DSR_W + QB;

  logic [W-1:0]     rem_r [QB];
  logic [QB-1:0]    quo_r [QB];
  logic [DSR_W-1:0] dsr_r [QB];

  for (genvar k = 0; k < QB; k++) begin : g_stage
    logic [W-1:0]     rem_in;
    logic [QB-1:0]    quo_in;
    logic [DSR_W-1:0] dsr_in;
    logic [W-1:0]     trial;
    logic             ge;
    logic [W-1:0]     rem_nxt;
    logic [QB-1:0]    quo_nxt;

    if (k == 0) begin : g_first
      assign rem_in = dvd_i;
      assign quo_in = '0;
      assign dsr_in = dsr_i;
    end else begin : g_next
      assign rem_in = rem_r[k-1];
      assign quo_in = quo_r[k-1];
      assign dsr_in = dsr_r[k-1];
    end

    assign trial   = W'(dsr_in) << (QB - 1 - k);
    assign ge      = rem_in >= trial;
    assign rem_nxt = ge ? rem_in - trial : rem_in;
    assign quo_nxt = quo_in | (QB'(ge) << (QB - 1 - k));

    always_ff @(posedge clk) begin
      rem_r[k] <= rem_nxt;
      quo_r[k] <= quo_nxt;
      dsr_r[k] <= dsr_in;
    end
  end

  assign quo_o = quo_r[QB-1];

endmodule

// ----- rtl/core/cubemap_bilinear_sampler.sv -----
// Cube map face select and bilinear texture sampler, top level.
// Depends on cbs_pkg, cbs_div (coordinate divide) and cbs_ram (texel banks).
//
// Takes one word per clock, write or sample, and never raises busy. A sample
// word passes the input, face select, dividend, divider, coordinate, texel
// read, row blend and output registers and returns with out_valid; a write
// word returns nothing. A bit-per-stage divider forms the texel coordinate.
// The receiver cannot stall, so out_data must be taken in the cycle out_valid
// is high. Texels sit in four RAM banks split by column and row parity, so
// the four bilinear neighbors are read in the same cycle. Writes pass down
// the same pipe as samples and hit the RAM in order. Sampling a texel that
// was never written returns undefined color. face_size may only be changed
// while no word is in flight.
module cubemap_bilinear_sampler #(
  parameter int MAX_FACE_SIZE = cbs_pkg::MAX_FACE_SIZE,
  parameter int CHANNEL_BITS  = cbs_pkg::CHANNEL_BITS,
  parameter int FRAC_BITS     = cbs_pkg::FRAC_BITS
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  cbs_pkg::in_word_t                   in_data,
  output logic                                out_valid,
  output cbs_pkg::out_word_t                  out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [cbs_pkg::FACE_SIZE_W-1:0]     cfg_data
);

  localparam int FB  = FRAC_BITS;
  localparam int CB  = CHANNEL_BITS;
  localparam int SB  = $clog2(MAX_FACE_SIZE + 1);
  localparam int CW  = $clog2(MAX_FACE_SIZE);
  localparam int QB  = SB + FB;
  localparam int DRW = cbs_pkg::DIR_W;
  localparam int NW  = DRW + 1;
  localparam int DW  = DRW + QB;
  localparam int HC  = (MAX_FACE_SIZE + 1) / 2;
  localparam int FPB = HC * HC;
  localparam int BD  = 6 * FPB;
  localparam int BA  = $clog2(BD);
  localparam int TW  = 3 * CB;
  localparam int S   = 1 << FB;
  localparam int BW  = CB + FB + 1;
  localparam int SW  = BW + FB + 1;

  typedef struct packed {
    logic          op;
    logic [2:0]    face;
    logic          zero;
    logic [2:0]    wface;
    logic [5:0]    col;
    logic [5:0]    row;
    logic [TW-1:0] wdata;
  } side_t;

  typedef struct packed {
    logic [CW-1:0] lo;
    logic [CW-1:0] hi;
    logic [FB-1:0] frac;
  } coord_t;

  function automatic coord_t map_c(logic [QB-1:0] q, logic [SB-1:0] sz);
    logic [QB:0]   t;
    logic [SB:0]   whole;
    logic [SB:0]   wm1;
    logic [SB:0]   szm1;
    logic [CW:0]   lo1;
    coord_t        c;
    t     = {1'b0, q} + (QB+1)'(S / 2);
    whole = t[QB:FB];
    wm1   = whole - (SB+1)'(1);
    szm1  = (SB+1)'(sz) - (SB+1)'(1);
    if (whole == '0) begin
      c.lo = '0;
    end else if (wm1 > szm1) begin
      c.lo = CW'(szm1);
    end else begin
      c.lo = CW'(wm1);
    end
    lo1    = {1'b0, c.lo} + (CW+1)'(1);
    c.hi   = (lo1 < (CW+1)'(sz)) ? CW'(lo1) : CW'(szm1);
    c.frac = t[FB-1:0];
    return c;
  endfunction

  function automatic logic [BA-1:0] bank_addr(logic [2:0] f, int unsigned rh,
                                               int unsigned chf);
    return BA'(int'(f) * FPB + int'(rh) * HC + int'(chf));
  endfunction

  // ---------------- configuration ----------------
  logic [cbs_pkg::FACE_SIZE_W-1:0] face_size_r;
  logic [SB-1:0]                   size_eff;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      face_size_r <= cbs_pkg::FACE_SIZE_RST;
    end else if (cfg_valid && cfg_ready) begin
      face_size_r <= cfg_data;
    end
  end

  always_comb begin
    if (face_size_r == '0) begin
      size_eff = SB'(1);
    end else if (32'(face_size_r) > MAX_FACE_SIZE) begin
      size_eff = SB'(MAX_FACE_SIZE);
    end else begin
      size_eff = SB'(face_size_r);
    end
  end

  assign cfg_ready = 1'b1;
  assign busy      = 1'b0;

  // ---------------- stage 1: input register ----------------
  logic              s1_v_r;
  cbs_pkg::in_word_t s1_d_r;

  // ---------------- stage 2: face select ----------------
  logic [DRW-1:0]         ax, ay, az, ma_c;
  logic signed [NW-1:0]   xs, ys, zs, sc_c, tc_c;
  logic [2:0]             face_c;
  logic                   zero_c;
  side_t                  side2_c;

  logic                   s2_v_r;
  side_t                  side2_r;
  logic [NW-1:0]          numx2_r, numy2_r;
  logic [DRW-1:0]         ma2_r;

  // ---------------- stage 3: scaled dividends ----------------
  logic [NW+SB-1:0]       prodx_c, prody_c;
  logic                   s3_v_r;
  side_t                  side3_r;
  logic [DW-1:0]          dvdx3_r, dvdy3_r;
  logic [DRW-1:0]         ma3_r;

  // ---------------- divider line ----------------
  logic [QB-1:0]          qx, qy;
  logic                   vline_r [QB];
  side_t                  sline_r [QB];

  // ---------------- stage 4: coordinates ----------------
  coord_t                 cx_c, cy_c;
  logic                   s4_v_r;
  side_t                  side4_r;
  coord_t                 cx4_r, cy4_r;

  // ---------------- RAM ports ----------------
  logic [3:0]             ram_we;
  logic [BA-1:0]          ram_waddr;
  logic [BA-1:0]          ram_raddr [4];
  logic [TW-1:0]          ram_rdata [4];
  logic                   wr_ok;
  logic [1:0]             wr_bank;

  // ---------------- stage 5: texel data ----------------
  logic                   s5_v_r;
  logic                   x0p5_r, x1p5_r, y0p5_r, y1p5_r;
  logic [FB-1:0]          fx5_r, fy5_r;
  logic [2:0]             face5_r;
  logic                   zero5_r;
  logic [TW-1:0]          c00, c10, c01, c11;
  logic [FB:0]            wx0, wx1;

  // ---------------- stage 6: row blends ----------------
  logic                   s6_v_r;
  logic [BW-1:0]          top6_r [3];
  logic [BW-1:0]          bot6_r [3];
  logic [FB-1:0]          fy6_r;
  logic [2:0]             face6_r;
  logic                   zero6_r;
  logic [FB:0]            wy0;
  logic [cbs_pkg::CHAN_W-1:0] col_c [3];

  // ---------------- output ----------------
  logic                   out_valid_r;
  cbs_pkg::out_word_t     out_data_r;
  cbs_pkg::out_word_t     out_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    s1_d_r <= in_data;
  end

  always_comb begin
    xs   = NW'(s1_d_r.dir_x);
    ys   = NW'(s1_d_r.dir_y);
    zs   = NW'(s1_d_r.dir_z);
    ax   = DRW'(xs[NW-1] ? -xs : xs);
    ay   = DRW'(ys[NW-1] ? -ys : ys);
    az   = DRW'(zs[NW-1] ? -zs : zs);
    zero_c = (ax == '0) && (ay == '0) && (az == '0);
    if (ax >= ay && ax >= az) begin
      ma_c = ax;
      tc_c = -ys;
      if (xs > 0) begin
        face_c = cbs_pkg::FACE_PX;
        sc_c   = -zs;
      end else begin
        face_c = cbs_pkg::FACE_NX;
        sc_c   = zs;
      end
    end else if (ay >= az) begin
      ma_c = ay;
      sc_c = xs;
      if (ys > 0) begin
        face_c = cbs_pkg::FACE_PY;
        tc_c   = zs;
      end else begin
        face_c = cbs_pkg::FACE_NY;
        tc_c   = -zs;
      end
    end else begin
      ma_c = az;
      tc_c = -ys;
      if (zs > 0) begin
        face_c = cbs_pkg::FACE_PZ;
        sc_c   = xs;
      end else begin
        face_c = cbs_pkg::FACE_NZ;
        sc_c   = -xs;
      end
    end
    side2_c.op    = s1_d_r.opcode;
    side2_c.face  = face_c;
    side2_c.zero  = zero_c;
    side2_c.wface = s1_d_r.write_face;
    side2_c.col   = s1_d_r.texel_col;
    side2_c.row   = s1_d_r.texel_row;
    side2_c.wdata = {CB'(s1_d_r.write_red), CB'(s1_d_r.write_green),
                     CB'(s1_d_r.write_blue)};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else begin
      s2_v_r <= s1_v_r;
    end
  end

  // sum of coordinate and major magnitude is never negative (up to 2*ma)
  always_ff @(posedge clk) begin
    side2_r <= side2_c;
    numx2_r <= NW'(sc_c + $signed({1'b0, ma_c}));
    numy2_r <= NW'(tc_c + $signed({1'b0, ma_c}));
    ma2_r   <= ma_c;
  end

  assign prodx_c = (NW+SB)'(numx2_r) * (NW+SB)'(size_eff);
  assign prody_c = (NW+SB)'(numy2_r) * (NW+SB)'(size_eff);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else begin
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    side3_r <= side2_r;
    dvdx3_r <= {prodx_c, (FB-1)'(0)};
    dvdy3_r <= {prody_c, (FB-1)'(0)};
    ma3_r   <= ma2_r;
  end

  cbs_div #(.DSR_W(DRW), .QB(QB)) u_divx (
    .clk   (clk),
    .dvd_i (dvdx3_r),
    .dsr_i (ma3_r),
    .quo_o (qx)
  );

  cbs_div #(.DSR_W(DRW), .QB(QB)) u_divy (
    .clk   (clk),
    .dvd_i (dvdy3_r),
    .dsr_i (ma3_r),
    .quo_o (qy)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < QB; k++) begin
        vline_r[k] <= 1'b0;
      end
    end else begin
      vline_r[0] <= s3_v_r;
      for (int k = 1; k < QB; k++) begin
        vline_r[k] <= vline_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    sline_r[0] <= side3_r;
    for (int k = 1; k < QB; k++) begin
      sline_r[k] <= sline_r[k-1];
    end
  end

  assign cx_c = map_c(qx, size_eff);
  assign cy_c = map_c(qy, size_eff);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_v_r <= 1'b0;
    end else begin
      s4_v_r <= vline_r[QB-1];
    end
  end

  always_ff @(posedge clk) begin
    side4_r <= sline_r[QB-1];
    cx4_r   <= cx_c;
    cy4_r   <= cy_c;
  end

  // Writes reach the banks at the same stage as sample reads, so order holds.
  always_comb begin
    wr_ok = (side4_r.wface <= cbs_pkg::FACE_NZ) &&
            (32'(side4_r.col) < MAX_FACE_SIZE) &&
            (32'(side4_r.row) < MAX_FACE_SIZE);
    wr_bank   = {side4_r.row[0], side4_r.col[0]};
    ram_waddr = bank_addr(side4_r.wface, 32'(side4_r.row) >> 1,
                          32'(side4_r.col) >> 1);
    for (int b = 0; b < 4; b++) begin
      ram_we[b] = s4_v_r && (side4_r.op == cbs_pkg::OP_WRITE) && wr_ok &&
                  (wr_bank == 2'(b));
    end
  end

  for (genvar b = 0; b < 4; b++) begin : g_bank
    logic [CW-1:0] rcol, rrow;
    // each bank holds one column parity and one row parity
    assign rcol = (cx4_r.lo[0] == 1'(b % 2)) ? cx4_r.lo : cx4_r.hi;
    assign rrow = (cy4_r.lo[0] == 1'(b / 2)) ? cy4_r.lo : cy4_r.hi;
    assign ram_raddr[b] = bank_addr(side4_r.face, 32'(rrow) >> 1, 32'(rcol) >> 1);

    cbs_ram #(.WIDTH(TW), .DEPTH(BD)) u_ram (
      .clk   (clk),
      .we    (ram_we[b]),
      .waddr (ram_waddr),
      .wdata (side4_r.wdata),
      .raddr (ram_raddr[b]),
      .rdata (ram_rdata[b])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_v_r <= 1'b0;
    end else begin
      s5_v_r <= s4_v_r && (side4_r.op == cbs_pkg::OP_SAMPLE);
    end
  end

  always_ff @(posedge clk) begin
    x0p5_r  <= cx4_r.lo[0];
    x1p5_r  <= cx4_r.hi[0];
    y0p5_r  <= cy4_r.lo[0];
    y1p5_r  <= cy4_r.hi[0];
    fx5_r   <= cx4_r.frac;
    fy5_r   <= cy4_r.frac;
    face5_r <= side4_r.face;
    zero5_r <= side4_r.zero;
  end

  assign c00 = ram_rdata[{y0p5_r, x0p5_r}];
  assign c10 = ram_rdata[{y0p5_r, x1p5_r}];
  assign c01 = ram_rdata[{y1p5_r, x0p5_r}];
  assign c11 = ram_rdata[{y1p5_r, x1p5_r}];
  assign wx1 = (FB+1)'(fx5_r);
  assign wx0 = (FB+1)'(S) - wx1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s6_v_r <= 1'b0;
    end else begin
      s6_v_r <= s5_v_r;
    end
  end

  // channel 0 is red, held in the top bits of the texel word
  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      top6_r[k] <= BW'(c00[(2-k)*CB +: CB]) * BW'(wx0) +
                   BW'(c10[(2-k)*CB +: CB]) * BW'(wx1);
      bot6_r[k] <= BW'(c01[(2-k)*CB +: CB]) * BW'(wx0) +
                   BW'(c11[(2-k)*CB +: CB]) * BW'(wx1);
    end
    fy6_r   <= fy5_r;
    face6_r <= face5_r;
    zero6_r <= zero5_r;
  end

  assign wy0 = (FB+1)'(S) - (FB+1)'(fy6_r);

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      col_c[k] = cbs_pkg::CHAN_W'((SW'(top6_r[k]) * SW'(wy0) +
                                   SW'(bot6_r[k]) * SW'(fy6_r)) >> (2 * FB));
    end
    if (zero6_r) begin
      out_nxt = '0;
      out_nxt.zero_dir_error = 1'b1;
    end else begin
      out_nxt.face_index     = face6_r;
      out_nxt.out_red        = col_c[0];
      out_nxt.out_green      = col_c[1];
      out_nxt.out_blue       = col_c[2];
      out_nxt.zero_dir_error = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= s6_v_r;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // ---------------- assertions ----------------
  a_no_wr_on_sample: assert property (@(posedge clk) disable iff (!rst_n)
    s4_v_r && (side4_r.op == cbs_pkg::OP_SAMPLE) |-> ram_we == '0)
    else $error("texel write issued in a sample slot");

  a_zero_dir_black: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.zero_dir_error |->
      out_data.out_red == '0 && out_data.out_green == '0 &&
      out_data.out_blue == '0 && out_data.face_index == cbs_pkg::FACE_PX)
    else $error("zero direction word carries color");

  a_face_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.face_index <= cbs_pkg::FACE_NZ)
    else $error("face index out of range");

  a_one_bank_write: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(ram_we))
    else $error("more than one texel bank written");

endmodule
